@@ design/spgc_pkg.sv @@
// Package for the swipe and palm gesture classifier.
// Holds the beat and configuration structs, register indexes, swipe codes and reset values.
// No dependencies.
package spgc_pkg;

  localparam int unsigned ColW   = 10;
  localparam int unsigned AreaW  = 21;
  localparam int unsigned ThrW   = 10;
  localparam int unsigned TrigW  = 4;
  localparam int unsigned RatioW = 8;
  localparam int unsigned HoldW  = 8;
  localparam int unsigned HcntW  = 9;
  localparam int unsigned ScoreW = 5;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 21;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SHIFT_THRESHOLD  = 3'd0,
    CFG_TRIGGER_SCORE    = 3'd1,
    CFG_PALM_RATIO_Q4    = 3'd2,
    CFG_PALM_AREA_FLOOR  = 3'd3,
    CFG_PALM_HOLD_FRAMES = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SWIPE_NONE  = 2'd0,
    SWIPE_LEFT  = 2'd1,
    SWIPE_RIGHT = 2'd2
  } swipe_e;

  localparam logic [ThrW-1:0]   RstShiftThreshold = 10'd6;
  localparam logic [TrigW-1:0]  RstTriggerScore   = 4'd4;
  localparam logic [RatioW-1:0] RstPalmRatioQ4    = 8'd40;
  localparam logic [AreaW-1:0]  RstPalmMinArea    = 21'd10000;
  localparam logic [HoldW-1:0]  RstPalmHoldFrames = 8'd30;

  typedef struct packed {
    logic              has_motion;
    logic [ColW-1:0]   left_col;
    logic [ColW-1:0]   right_col;
    logic [AreaW-1:0]  pixel_count;
  } in_t;

  typedef struct packed {
    logic       stop_event;
    logic [1:0] swipe_event;
    logic       palm_now;
  } out_t;

  typedef struct packed {
    logic [ThrW-1:0]   shift_threshold;
    logic [TrigW-1:0]  trigger_score;
    logic [RatioW-1:0] palm_ratio_q4;
    logic [AreaW-1:0]  palm_area_floor;
    logic [HoldW-1:0]  palm_hold_frames;
  } cfg_t;

  typedef struct packed {
    logic                     palm_active;
    logic [HcntW-1:0]         hold_count;
    logic [AreaW-1:0]         last_count;
    logic signed [ScoreW-1:0] score;
    logic                     prev_valid;
    logic [ColW-1:0]          prev_left;
    logic [ColW-1:0]          prev_right;
  } state_t;

endpackage

@@ design/spgc_cfg_regs.sv @@
// Configuration register file of the gesture classifier.
// Depends on spgc_pkg.
module spgc_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [spgc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [spgc_pkg::CfgDataW-1:0]   cfg_data_i,
  output spgc_pkg::cfg_t                  cfg_o
);
  import spgc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SHIFT_THRESHOLD:  cfg_d.shift_threshold  = cfg_data_i[ThrW-1:0];
        CFG_TRIGGER_SCORE:    cfg_d.trigger_score    = cfg_data_i[TrigW-1:0];
        CFG_PALM_RATIO_Q4:    cfg_d.palm_ratio_q4    = cfg_data_i[RatioW-1:0];
        CFG_PALM_AREA_FLOOR:  cfg_d.palm_area_floor  = cfg_data_i[AreaW-1:0];
        CFG_PALM_HOLD_FRAMES: cfg_d.palm_hold_frames = cfg_data_i[HoldW-1:0];
        default:              cfg_d = cfg_q;  // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.shift_threshold  <= RstShiftThreshold;
      cfg_q.trigger_score    <= RstTriggerScore;
      cfg_q.palm_ratio_q4    <= RstPalmRatioQ4;
      cfg_q.palm_area_floor  <= RstPalmMinArea;
      cfg_q.palm_hold_frames <= RstPalmHoldFrames;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/spgc_step.sv @@
// Per-frame update of the classifier: palm test, hold counter, swipe score.
// Pure combinational; depends on spgc_pkg.
module spgc_step (
  input  spgc_pkg::cfg_t   cfg_i,
  input  spgc_pkg::state_t st_i,
  input  spgc_pkg::in_t    item_i,
  output spgc_pkg::state_t st_o,
  output spgc_pkg::out_t   res_o
);
  import spgc_pkg::*;

  logic [AreaW+3:0]          area_x16;
  logic [RatioW+AreaW-1:0]   ratio_prod;
  logic                      ratio_hit;
  logic                      area_hit;
  logic signed [ColW+1:0]    dmax;
  logic signed [ColW+1:0]    dmin;
  logic signed [ColW+1:0]    thr_s;
  logic signed [ScoreW-1:0]  trig_s;
  logic                      fired;
  logic                      stop;
  swipe_e                    swipe;
  state_t                    st;

  // Q4.4 ratio test as exact integer compare: count*16 > ratio*last
  assign area_x16   = {item_i.pixel_count, 4'b0000};
  assign ratio_prod = cfg_i.palm_ratio_q4 * st_i.last_count;
  assign ratio_hit  = {4'b0000, area_x16} > ratio_prod;
  assign area_hit   = item_i.pixel_count > cfg_i.palm_area_floor;

  assign dmax   = $signed({2'b00, item_i.right_col}) - $signed({2'b00, st_i.prev_right});
  assign dmin   = $signed({2'b00, item_i.left_col}) - $signed({2'b00, st_i.prev_left});
  assign thr_s  = $signed({2'b00, cfg_i.shift_threshold});
  assign trig_s = $signed({1'b0, cfg_i.trigger_score});

  always_comb begin
    st    = st_i;
    stop  = 1'b0;
    swipe = SWIPE_NONE;
    fired = 1'b0;
    if (item_i.has_motion) begin
      if (!st.palm_active && (st.last_count != '0) && ratio_hit && area_hit) begin
        stop           = 1'b1;
        st.palm_active = 1'b1;
        st.hold_count  = '0;
      end
      if (st.palm_active) begin
        st.hold_count = st.hold_count + 1'b1;
        if (st.hold_count > {1'b0, cfg_i.palm_hold_frames}) begin
          st.palm_active = 1'b0;
          st.hold_count  = '0;
        end
      end
      st.last_count = item_i.pixel_count;

      if (!st.palm_active) begin
        if (st.prev_valid) begin
          if (dmax > thr_s) begin
            st.score = (st.score >= 0) ? st.score + 5'sd1 : '0;
          end else if (dmin < -thr_s) begin
            st.score = (st.score <= 0) ? st.score - 5'sd1 : '0;
          end else if (st.score > 0) begin
            st.score = st.score - 5'sd1;
          end else if (st.score < 0) begin
            st.score = st.score + 5'sd1;
          end
          if (st.score >= trig_s) begin
            swipe = SWIPE_LEFT;
            fired = 1'b1;
          end else if (st.score <= -trig_s) begin
            swipe = SWIPE_RIGHT;
            fired = 1'b1;
          end
          if (fired) begin
            st.score      = '0;
            st.prev_valid = 1'b0;
          end
        end
        if (!fired) begin
          st.prev_left  = item_i.left_col;
          st.prev_right = item_i.right_col;
          st.prev_valid = 1'b1;
        end
      end else begin
        // palm held: score frozen, edges tracked
        st.prev_left  = item_i.left_col;
        st.prev_right = item_i.right_col;
        st.prev_valid = 1'b1;
      end
    end else if (!st.palm_active) begin
      st.score = '0;
    end
  end

  assign st_o              = st;
  assign res_o.stop_event  = stop;
  assign res_o.swipe_event = swipe;
  assign res_o.palm_now    = st.palm_active;

endmodule

@@ design/swipe_and_palm_gesture_classifier.sv @@
// Top level of the swipe and palm gesture classifier.
// Depends on spgc_pkg, spgc_cfg_regs and spgc_step.
//
// One input beat per video frame gives the motion flag, the mask's edge columns and its
// pixel count; exactly one result beat comes back per input beat, in order. A beat lands
// in an input register, the frame update (one 8x21 multiply for the Q4.4 palm ratio plus
// compares and a small score adder) runs between that register and the result register,
// and the classifier state is written as the beat moves into the result register. The
// result is registered in the result register, behind the input register; throughput is one
// beat per cycle while the result side keeps out_ready_i high, and one new beat is taken into
// the input register while a finished result waits for out_ready_i. Configuration writes
// are always accepted (cfg_ready_o is tied high) and take effect on the next cycle; write
// them only while no frame is in flight. Writes to unmapped indexes are dropped.
module swipe_and_palm_gesture_classifier (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // frame beats in
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  spgc_pkg::in_t                  in_data_i,
  // result beats out
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output spgc_pkg::out_t                 out_data_o,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [spgc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [spgc_pkg::CfgDataW-1:0]  cfg_data_i
);
  import spgc_pkg::*;

  cfg_t   cfg;
  state_t st_q, st_d;
  out_t   res_d;
  logic   in_valid_q;
  in_t    in_data_q;
  logic   out_valid_q;
  out_t   out_data_q;
  logic   advance;

  spgc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  spgc_step u_step (
    .cfg_i  (cfg),
    .st_i   (st_q),
    .item_i (in_data_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  assign cfg_ready_o = 1'b1;

  // beat moves from the input register into the result register
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        st_q        <= st_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
